// ===== hdl/mbmd_pkg.sv =====
package mbmd_pkg;

    // Code register geometry
    localparam int MAX_CODE_LEN = 6;
    localparam int CODE_LEN_W   = $clog2(MAX_CODE_LEN + 1);

    // Button bit positions in the report byte
    localparam int BTN_LEFT_BIT   = 0;
    localparam int BTN_RIGHT_BIT  = 1;
    localparam int BTN_MIDDLE_BIT = 2;
    localparam int BTN_THUMB2_BIT = 3;
    localparam int BTN_THUMB1_BIT = 4;

    // Output queue depth (most results one item can cause)
    localparam int QUEUE_DEPTH = 2;
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] ASCII_SPACE = 7'h20;

    // One result item
    typedef struct packed {
        logic [6:0] char_code;
        logic       char_valid;
        logic       message_end;
        logic       last;
    } t_result;

    // Decoder to queue: results of the item in the input register
    typedef struct packed {
        logic [QCOUNT_W-1:0] need;
        t_result             res0;
        t_result             res1;
    } t_dec_out;

    // Morse lookup: first symbol is the MSB of the len low bits, dash = 1.
    // Returns 0 for codes not in the table. Table codes are at most six
    // symbols long, so the key keeps three length bits and six code bits.
    function automatic logic [6:0] mbmd_lookup(input logic [CODE_LEN_W-1:0] len,
                                               input logic [MAX_CODE_LEN-1:0] bits);
        logic [6:0] ch;
        ch = 7'd0;
        case ({3'(len), 6'(bits)})
            // letters
            {3'd2, 6'd1}:  ch = 7'("A");
            {3'd4, 6'd8}:  ch = 7'("B");
            {3'd4, 6'd10}: ch = 7'("C");
            {3'd3, 6'd4}:  ch = 7'("D");
            {3'd1, 6'd0}:  ch = 7'("E");
            {3'd4, 6'd2}:  ch = 7'("F");
            {3'd3, 6'd6}:  ch = 7'("G");
            {3'd4, 6'd0}:  ch = 7'("H");
            {3'd2, 6'd0}:  ch = 7'("I");
            {3'd4, 6'd7}:  ch = 7'("J");
            {3'd3, 6'd5}:  ch = 7'("K");
            {3'd4, 6'd4}:  ch = 7'("L");
            {3'd2, 6'd3}:  ch = 7'("M");
            {3'd2, 6'd2}:  ch = 7'("N");
            {3'd3, 6'd7}:  ch = 7'("O");
            {3'd4, 6'd6}:  ch = 7'("P");
            {3'd4, 6'd13}: ch = 7'("Q");
            {3'd3, 6'd2}:  ch = 7'("R");
            {3'd3, 6'd0}:  ch = 7'("S");
            {3'd1, 6'd1}:  ch = 7'("T");
            {3'd3, 6'd1}:  ch = 7'("U");
            {3'd4, 6'd1}:  ch = 7'("V");
            {3'd3, 6'd3}:  ch = 7'("W");
            {3'd4, 6'd9}:  ch = 7'("X");
            {3'd4, 6'd11}: ch = 7'("Y");
            {3'd4, 6'd12}: ch = 7'("Z");
            // digits
            {3'd5, 6'd31}: ch = 7'("0");
            {3'd5, 6'd15}: ch = 7'("1");
            {3'd5, 6'd7}:  ch = 7'("2");
            {3'd5, 6'd3}:  ch = 7'("3");
            {3'd5, 6'd1}:  ch = 7'("4");
            {3'd5, 6'd0}:  ch = 7'("5");
            {3'd5, 6'd16}: ch = 7'("6");
            {3'd5, 6'd24}: ch = 7'("7");
            {3'd5, 6'd28}: ch = 7'("8");
            {3'd5, 6'd30}: ch = 7'("9");
            // punctuation
            {3'd6, 6'd43}: ch = 7'("!");
            {3'd5, 6'd10}: ch = 7'("+");
            {3'd6, 6'd51}: ch = 7'(",");
            {3'd6, 6'd33}: ch = 7'("-");
            {3'd6, 6'd21}: ch = 7'(".");
            {3'd5, 6'd18}: ch = 7'("/");
            {3'd6, 6'd56}: ch = 7'(":");
            {3'd6, 6'd42}: ch = 7'(";");
            {3'd5, 6'd17}: ch = 7'("=");
            {3'd6, 6'd12}: ch = 7'("?");
            default:       ch = 7'd0;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/mbmd_decode.sv =====
module mbmd_decode
    import mbmd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_buttons,   // report byte held in the input register
    input  logic       i_fire,      // item is consumed this cycle
    output t_dec_out   o_dec
);

    logic [MAX_CODE_LEN-1:0] r_code_bits, n_code_bits;
    logic [CODE_LEN_W-1:0]   r_code_len,  n_code_len;
    logic                    r_code_ovf,  n_code_ovf;

    logic       w_left, w_right, w_gap, w_word, w_end, w_sym, w_full, w_hit;
    logic [6:0] w_ch;

    // Symbol priority: left, right, thumb1/thumb2, middle
    assign w_left  = i_buttons[BTN_LEFT_BIT];
    assign w_right = !w_left && i_buttons[BTN_RIGHT_BIT];
    assign w_gap   = !w_left && !i_buttons[BTN_RIGHT_BIT]
                  && (i_buttons[BTN_THUMB1_BIT] || i_buttons[BTN_THUMB2_BIT]);
    assign w_word  = w_gap && !i_buttons[BTN_THUMB1_BIT];
    assign w_end   = !w_left && !i_buttons[BTN_RIGHT_BIT]
                  && !i_buttons[BTN_THUMB1_BIT] && !i_buttons[BTN_THUMB2_BIT]
                  && i_buttons[BTN_MIDDLE_BIT];
    assign w_sym   = w_left || w_right;
    assign w_full  = (r_code_len >= CODE_LEN_W'(MAX_CODE_LEN));

    // Table lookup of the gathered code; overflow gives no character
    assign w_ch  = r_code_ovf ? 7'd0 : mbmd_lookup(r_code_len, r_code_bits);
    assign w_hit = (w_ch != 7'd0);

    // Results of this item
    always_comb begin
        o_dec      = '0;
        if (w_gap) begin
            if (w_hit) begin
                o_dec.res0 = '{char_code: w_ch, char_valid: 1'b1,
                               message_end: 1'b0, last: !w_word};
                if (w_word) begin
                    o_dec.res1 = '{char_code: ASCII_SPACE, char_valid: 1'b1,
                                   message_end: 1'b0, last: 1'b1};
                end
            end else if (w_word) begin
                o_dec.res0 = '{char_code: ASCII_SPACE, char_valid: 1'b1,
                               message_end: 1'b0, last: 1'b1};
            end
            o_dec.need = QCOUNT_W'(w_hit) + QCOUNT_W'(w_word);
        end else if (w_end) begin
            o_dec.res0 = '{char_code: w_ch, char_valid: w_hit,
                           message_end: 1'b1, last: 1'b1};
            o_dec.need = QCOUNT_W'(1);
        end
    end

    // Code register update
    always_comb begin
        n_code_bits = r_code_bits;
        n_code_len  = r_code_len;
        n_code_ovf  = r_code_ovf;
        if (w_sym) begin
            if (w_full) begin
                n_code_ovf = 1'b1;
            end else begin
                n_code_bits = {r_code_bits[MAX_CODE_LEN-2:0], w_right};
                n_code_len  = r_code_len + CODE_LEN_W'(1);
            end
        end else if (w_gap || w_end) begin
            n_code_bits = '0;
            n_code_len  = '0;
            n_code_ovf  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits <= '0;
            r_code_len  <= '0;
            r_code_ovf  <= 1'b0;
        end else if (i_fire) begin
            r_code_bits <= n_code_bits;
            r_code_len  <= n_code_len;
            r_code_ovf  <= n_code_ovf;
        end
    end

endmodule

// ===== hdl/mbmd_out_queue.sv =====
module mbmd_out_queue
    import mbmd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [QCOUNT_W-1:0] i_push,    // number of results written this cycle
    input  t_result             i_res0,
    input  t_result             i_res1,
    input  logic                i_pop,     // head taken by the receiver
    output logic [QCOUNT_W-1:0] o_count,
    output t_result             o_head
);

    t_result             r_slot [QUEUE_DEPTH];
    t_result             n_slot [QUEUE_DEPTH];
    logic [QCOUNT_W-1:0] r_count, n_count;
    logic [QCOUNT_W-1:0] w_cnt_a;
    logic                w_pop;

    assign w_pop = i_pop && (r_count != '0);

    // Pop shifts the head out, then new results append behind what is left
    always_comb begin
        n_slot  = r_slot;
        w_cnt_a = r_count;
        if (w_pop) begin
            n_slot[0] = r_slot[1];
            w_cnt_a   = r_count - QCOUNT_W'(1);
        end
        if (i_push != '0) begin
            n_slot[w_cnt_a[0]] = i_res0;
        end
        if (i_push == QCOUNT_W'(2)) begin
            n_slot[1] = i_res1;
        end
        n_count = w_cnt_a + i_push;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_slot <= n_slot;
    end

    assign o_count = r_count;
    assign o_head  = r_slot[0];

endmodule

// ===== hdl/mouse_button_morse_decoder_top.sv =====
// Mouse-button Morse decoder.
// Input stream: one mouse report button byte per item on s_axis_tdata
// (left = dot, right = dash, thumb1 = letter gap, thumb2 = word gap,
// middle = end of message; reports with none of these are dropped).
// Output stream: decoded ASCII characters on m_axis_tdata, with char_valid
// and message_end on m_axis_tuser and tlast on the final result of an item.
// An item causes zero, one or two results.
// A result goes from its item through the input register, then the output
// queue register, before it is presented on m_axis.
// Throughput: one item per cycle while its results fit in the queue. The
// two-entry output queue takes an item only when all of its results fit
// beside those already queued; a pop in the same cycle is not counted, so
// an item can wait even with the receiver always ready.
// Reset (i_rst_n low, synchronous) clears the code register and empties the
// input register and the output queue.
// When the receiver stalls, the queue fills and s_axis_tready drops; no
// result is lost or repeated. s_axis_tready does not depend on m_axis_tready.
module mouse_button_morse_decoder_top
    import mbmd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] buttons
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] char_code, [7] zero
    output logic [1:0] m_axis_tuser,   // [0] char_valid, [1] message_end
    output logic       m_axis_tlast
);

    logic                r_in_valid;
    logic [7:0]          r_in_buttons;
    logic                w_fire, w_in_acc;
    t_dec_out            w_dec;
    logic [QCOUNT_W-1:0] w_count;
    logic [QCOUNT_W:0]   w_fill;
    t_result             w_head;

    // Fire when every result of the held item fits in the queue
    assign w_fill        = {1'b0, w_count} + {1'b0, w_dec.need};
    assign w_fire        = r_in_valid && (w_fill <= (QCOUNT_W + 1)'(QUEUE_DEPTH));
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_acc) begin
            r_in_buttons <= s_axis_tdata;
        end
    end

    mbmd_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_buttons (r_in_buttons),
        .i_fire    (w_fire),
        .o_dec     (w_dec)
    );

    mbmd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire ? w_dec.need : '0),
        .i_res0  (w_dec.res0),
        .i_res1  (w_dec.res1),
        .i_pop   (m_axis_tready),
        .o_count (w_count),
        .o_head  (w_head)
    );

    assign m_axis_tvalid = (w_count != '0);
    assign m_axis_tdata  = {1'b0, w_head.char_code};
    assign m_axis_tuser  = {w_head.message_end, w_head.char_valid};
    assign m_axis_tlast  = w_head.last;

    // Queue never holds more than its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= QCOUNT_W'(QUEUE_DEPTH))
        else $error("output queue over depth");

    // Two results from one item: only the second carries tlast
    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_dec.need == QCOUNT_W'(2)) |-> (!w_dec.res0.last && w_dec.res1.last))
        else $error("bad tlast on result pair");

    // An end-of-message result is always the final one of its item
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
        else $error("message end without tlast");

    // With no push, either no item fired or the fired item had no results, the queue count cannot grow
    a_no_push_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_fire || w_dec.need == '0) |=> (w_count <= $past(w_count)))
        else $error("queue grew without a push");

endmodule
